FILE: rtl/core/oneshot_periodic_soft_timer_assert.svh
// assertion macros for the one-shot / periodic timer checks
`ifndef ONESHOT_PERIODIC_SOFT_TIMER_ASSERT_SVH
`define ONESHOT_PERIODIC_SOFT_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OPST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OPST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/opst_pkg.sv
// shared types and constants of the one-shot / periodic timer
`timescale 1ns / 1ps
`default_nettype none

package opst_pkg;

  localparam logic [1:0] ACT_POLL    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;

  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_ONESHOT  = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;

  localparam logic [1:0] CFG_TICK_FREQ    = 2'd0;
  localparam logic [1:0] CFG_TIMER_AMOUNT = 2'd1;
  localparam logic [1:0] CFG_AMOUNT_IS_MS = 2'd2;
  localparam logic [1:0] CFG_START_MODE   = 2'd3;

  localparam logic [15:0] TICK_FREQ_RST    = 16'd1000;
  localparam logic [15:0] TIMER_AMOUNT_RST = 16'd1000;

  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [22:0] MS_DIVISOR = 23'd1000;

  localparam logic [5:0] DIV_FULL_STEPS  = 6'd32;
  localparam logic [5:0] DIV_SHORT_STEPS = 6'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] tick_now;
  } in_item_t;

  typedef struct packed {
    logic        finished;
    logic [6:0]  progress_pct;
    logic [1:0]  mode_now;
  } out_item_t;

  typedef struct packed {
    logic        go;
    logic        short_run;
    logic [31:0] dividend;
    logic [22:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAP,
    S_PCT,
    S_PWAIT,
    S_QSTART,
    S_QWAIT,
    S_UPD
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/opst_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module opst_div import opst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [22:0] rem_r;
  logic [31:0] quo_r;
  logic [22:0] divisor_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [23:0] trial;
  logic [23:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[31]};
  assign ge    = trial >= {1'b0, divisor_r};
  assign diff  = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.go && busy_r && (cnt_r == 6'd1);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_run ? DIV_SHORT_STEPS : DIV_FULL_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) busy_r <= 1'b0;
      end
    end
  end

  // short run: quotient known to fit 7 bits, so the upper dividend bits preload the remainder
  always_ff @(posedge clk) begin
    if (req.go) begin
      divisor_r <= req.divisor;
      if (req.short_run) begin
        rem_r <= req.dividend[29:7];
        quo_r <= {req.dividend[6:0], 25'd0};
      end else begin
        rem_r <= '0;
        quo_r <= req.dividend;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[22:0] : trial[22:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/oneshot_periodic_soft_timer.sv
// top level of the one-shot / periodic timer against a free-running tick count
//
//   port group   direction   handshake          payload
//   in_*         input       in_valid/in_stall  in_item   (action, tick_now)
//   out_*        output      out_valid/out_stall out_item (finished, progress_pct, mode_now)
//   cfg_*        input       cfg_we             cfg_index, cfg_wdata
//
// from accept to result an item passes S_ELAP, S_PCT and S_QSTART to S_UPD; only start items
// also divide for the period (a start with a zero divisor does not), and a stalled output holds S_UPD
// both divisions use the shared bit-serial divider: 7 steps for progress, skipped when
// progress is full, and 32 for the period
// one item is in work at a time; the next is taken as soon as the core is back in idle
// a finished result sits in the output register until out_stall drops, the core waits on it
// rst_n clears timer state to disabled, deadline 0, period 0 and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module oneshot_periodic_soft_timer import opst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] tick_freq_r;
  logic [15:0] timer_amount_r;
  logic        amount_is_ms_r;
  logic [1:0]  start_mode_r;

  logic [1:0]  timer_mode_r;
  logic [31:0] deadline_r;
  logic [22:0] period_len_r;

  state_t      state_r, state_nxt;
  logic [1:0]  action_r;
  logic [31:0] now_r;
  logic [31:0] elapsed_r;
  logic [31:0] prod_r;
  logic [6:0]  pct_r;
  logic [22:0] new_period_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        out_free;
  logic        pct_sat;
  logic [29:0] elap_ext;
  logic [29:0] elap_x100;
  logic [22:0] add_per;
  logic [31:0] reload;
  logic        fin;
  logic [1:0]  mode_nxt;
  logic [31:0] deadline_nxt;
  logic [22:0] period_nxt;

  opst_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_freq_r    <= TICK_FREQ_RST;
      timer_amount_r <= TIMER_AMOUNT_RST;
      amount_is_ms_r <= 1'b1;
      start_mode_r   <= MODE_ONESHOT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICK_FREQ:    tick_freq_r    <= cfg_wdata;
        CFG_TIMER_AMOUNT: timer_amount_r <= cfg_wdata;
        CFG_AMOUNT_IS_MS: amount_is_ms_r <= cfg_wdata[0];
        CFG_START_MODE:   start_mode_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign pct_sat   = (period_len_r == '0) || (elapsed_r >= {9'd0, period_len_r});
  assign elap_ext  = {7'd0, elapsed_r[22:0]};
  assign elap_x100 = (elap_ext << 6) + (elap_ext << 5) + (elap_ext << 2);

  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ELAP;
      end
      S_ELAP: begin
        state_nxt = S_PCT;
      end
      S_PCT: begin
        if (pct_sat) begin
          state_nxt = S_QSTART;
        end else begin
          div_req.go        = 1'b1;
          div_req.short_run = 1'b1;
          div_req.dividend  = {2'd0, elap_x100};
          div_req.divisor   = period_len_r;
          state_nxt         = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (div_rsp.done) state_nxt = S_QSTART;
      end
      S_QSTART: begin
        if (action_r != ACT_START) begin
          state_nxt = S_UPD;
        end else if (amount_is_ms_r) begin
          div_req.go       = 1'b1;
          div_req.dividend = prod_r;
          div_req.divisor  = MS_DIVISOR;
          state_nxt        = S_QWAIT;
        end else if (timer_amount_r == '0) begin
          state_nxt = S_UPD;
        end else begin
          div_req.go       = 1'b1;
          div_req.dividend = {16'd0, tick_freq_r};
          div_req.divisor  = {7'd0, timer_amount_r};
          state_nxt        = S_QWAIT;
        end
      end
      S_QWAIT: begin
        if (div_rsp.done) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // timer state update, from the state before the item
  assign add_per = (action_r == ACT_START) ? new_period_r : period_len_r;
  assign reload  = now_r + {9'd0, add_per};

  always_comb begin
    fin          = 1'b0;
    mode_nxt     = timer_mode_r;
    deadline_nxt = deadline_r;
    period_nxt   = period_len_r;
    case (action_r)
      ACT_POLL: begin
        if (timer_mode_r != MODE_DISABLED && now_r >= deadline_r) begin
          fin = 1'b1;
          if (timer_mode_r == MODE_PERIODIC) begin
            deadline_nxt = reload;
          end else begin
            mode_nxt = MODE_DISABLED;
          end
        end
      end
      ACT_RESTART: begin
        deadline_nxt = reload;
        if (timer_mode_r == MODE_DISABLED) mode_nxt = MODE_ONESHOT;
      end
      ACT_START: begin
        period_nxt   = new_period_r;
        deadline_nxt = reload;
        mode_nxt     = (start_mode_r > MODE_PERIODIC) ? MODE_DISABLED : start_mode_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_mode_r <= MODE_DISABLED;
      deadline_r   <= '0;
      period_len_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_UPD && out_free) begin
        timer_mode_r <= mode_nxt;
        deadline_r   <= deadline_nxt;
        period_len_r <= period_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      action_r <= in_item.action;
      now_r    <= in_item.tick_now;
    end
    if (state_r == S_ELAP) begin
      elapsed_r    <= now_r - (deadline_r - {9'd0, period_len_r});
      prod_r       <= {16'd0, tick_freq_r} * {16'd0, timer_amount_r};
      new_period_r <= '0;
    end
    if (state_r == S_PCT && pct_sat) pct_r <= PCT_FULL;
    if (state_r == S_PWAIT && div_rsp.done) pct_r <= div_rsp.quotient[6:0];
    if (state_r == S_QWAIT && div_rsp.done) new_period_r <= div_rsp.quotient[22:0];
    if (state_r == S_UPD && out_free) begin
      out_item_r.finished     <= fin;
      out_item_r.progress_pct <= pct_r;
      out_item_r.mode_now     <= mode_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: rtl/core/opst_chk.sv
// port-level checks of the one-shot / periodic timer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "oneshot_periodic_soft_timer_assert.svh"

module opst_chk import opst_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `OPST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")
  `OPST_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while one is in work")
  `OPST_ASSERT_NOW(a_pct_range, out_valid, out_item.progress_pct <= PCT_FULL, "progress above full")
  `OPST_ASSERT_NOW(a_mode_code, out_valid, out_item.mode_now <= MODE_PERIODIC, "mode code out of range")
  `OPST_ASSERT_NOW(a_fin_mode, out_valid && out_item.finished, out_item.mode_now == MODE_DISABLED || out_item.mode_now == MODE_PERIODIC, "finished with wrong mode")

endmodule

bind oneshot_periodic_soft_timer opst_chk u_opst_chk (.*);

`default_nettype wire
